### rtl/vp8bd_pkg.sv
// Shared types, codes and constants of the VP8 boolean decoder.
package vp8bd_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT  = 24;

   localparam int OP_BITS       = 2;
   localparam int BYTE_BITS     = 8;
   localparam int COUNT_BITS    = 5;
   localparam int VALUE_BITS    = 16;
   localparam int STATUS_BITS   = 2;
   localparam int CODE_BITS     = 32;
   localparam int POSITION_BITS = 6;

   localparam logic [7:0]               RANGE_RESET      = 8'd254;
   localparam logic [POSITION_BITS-1:0] POSITION_RESET   = 6'b111000;
   localparam logic [POSITION_BITS-1:0] BYTE_STEP        = 6'd8;
   localparam logic [7:0]               LITERAL_PROB     = 8'd128;
   localparam logic [COUNT_BITS-1:0]    LITERAL_MAX_BITS = 5'd16;

   typedef enum logic [OP_BITS-1:0] {
      OP_RESTART = 2'd0,
      OP_PUSH    = 2'd1,
      OP_BOOL    = 2'd2,
      OP_LITERAL = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_RETRY    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] value;
      logic [7:0]           range;
      logic [4:0]           position;
      logic [7:0]           probability;
   } bit_operands_type;

   typedef struct packed {
      logic                 decoded_bit;
      logic [CODE_BITS-1:0] value;
      logic [7:0]           range;
      logic [2:0]           shift;
   } bit_result_type;

endpackage

### rtl/vp8bd_req_if.sv
// Request channel: operation and its operands.
interface vp8bd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [vp8bd_pkg::OP_BITS-1:0]        operation;
   logic [vp8bd_pkg::BYTE_BITS-1:0]      data_byte;
   logic [vp8bd_pkg::BYTE_BITS-1:0]      probability;
   logic [vp8bd_pkg::COUNT_BITS-1:0]     bit_count;

   modport source (output valid, operation, data_byte, probability, bit_count, input ready);
   modport sink   (input valid, operation, data_byte, probability, bit_count, output ready);
endinterface

### rtl/vp8bd_rsp_if.sv
// Response channel: decoded value, status and end-of-stream flag.
interface vp8bd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [vp8bd_pkg::VALUE_BITS-1:0]     decoded_value;
   logic [vp8bd_pkg::STATUS_BITS-1:0]    status;
   logic                                 stream_ended;

   modport source (output valid, decoded_value, status, stream_ended, input ready);
   modport sink   (input valid, decoded_value, status, stream_ended, output ready);
endinterface

### rtl/vp8bd_csr_if.sv
// Configuration write channel carrying the partition length.
interface vp8bd_csr_if #(
   parameter int DATA_BITS = vp8bd_pkg::LENGTH_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/vp8_bool_decoder.sv
// Top level of the VP8 boolean decoder: sequencer, decoder state and channel registers.
//
//   channel  direction  payload                                     transfer when
//   req_chan in         operation, data_byte, probability, bit_count valid && ready
//   rsp_chan out        decoded_value, status, stream_ended          valid && ready
//   csr_chan in         data (partition_length)                      valid && ready
//
// Restart, push and a zero-bit literal go from the transfer to the step that loads the response
// register. A bool decode and a literal of n bits run the start, multiply and decide steps for
// each bit, with 0, 1 or 3 refill bytes before a bit (each one fetch and one load of the store),
// then commit the working state and load the response register; a short buffer skips to the load with a retry.
// Synchronous active-high reset restores the restart state, an empty buffer and a zero length.
// A request is taken while an earlier response waits; a stall holds only the final step.
module vp8_bool_decoder #(
   parameter int BUFFER_DEPTH = vp8bd_pkg::BUFFER_DEPTH_DEFAULT,
   parameter int LENGTH_BITS  = vp8bd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   vp8bd_req_if.sink     req_chan,
   vp8bd_rsp_if.source   rsp_chan,
   vp8bd_csr_if.sink     csr_chan
);

   localparam int PTR_W  = $clog2(BUFFER_DEPTH);
   localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
   localparam int POS_W  = vp8bd_pkg::POSITION_BITS;
   localparam int CODE_W = vp8bd_pkg::CODE_BITS;
   localparam int CNT_W  = vp8bd_pkg::COUNT_BITS;
   localparam int VAL_W  = vp8bd_pkg::VALUE_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BIT_START,
      S_FETCH,
      S_LOAD,
      S_MUL,
      S_DECIDE,
      S_COMMIT,
      S_FINISH
   } state_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // Sequencer and committed decoder state.
   state_type             state_ff, state_in;
   logic [LENGTH_BITS-1:0] partition_ff, partition_in;
   logic [CODE_W-1:0]     cm_value_ff, cm_value_in;
   logic [7:0]            cm_range_ff, cm_range_in;
   logic [POS_W-1:0]      cm_pos_ff, cm_pos_in;
   logic                  cm_end_ff, cm_end_in;
   logic [LENGTH_BITS-1:0] cm_bytes_ff, cm_bytes_in;
   logic [PTR_W-1:0]      cm_rd_ff, cm_rd_in;
   logic [PTR_W-1:0]      cm_wr_ff, cm_wr_in;
   logic [FILL_W-1:0]     cm_fill_ff, cm_fill_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working copy used while a decode request runs; it is committed only
   // when every bit of the request has been decoded.
   logic [CODE_W-1:0]     wk_value_ff, wk_value_in;
   logic [7:0]            wk_range_ff, wk_range_in;
   logic [POS_W-1:0]      wk_pos_ff, wk_pos_in;
   logic                  wk_end_ff, wk_end_in;
   logic [LENGTH_BITS-1:0] wk_bytes_ff, wk_bytes_in;
   logic [PTR_W-1:0]      wk_rd_ff, wk_rd_in;
   logic [FILL_W-1:0]     wk_fill_ff, wk_fill_in;
   logic [CNT_W-1:0]      bits_left_ff, bits_left_in;
   logic [7:0]            prob_ff, prob_in;
   logic [VAL_W-1:0]      acc_ff, acc_in;
   logic [1:0]            refill_cnt_ff, refill_cnt_in;
   logic [VAL_W-1:0]      res_value_ff, res_value_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [VAL_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic                  mem_wr_en;
   logic [7:0]            mem_rd_data;
   logic                  unit_mul_en;
   vp8bd_pkg::bit_operands_type unit_operands;
   vp8bd_pkg::bit_result_type   unit_result;
   logic [3:0]            acc_index;

   vp8bd_byte_store #(
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cm_wr_ff),
      .wr_data (req_chan.data_byte),
      .rd_addr (wk_rd_ff),
      .rd_data (mem_rd_data)
   );

   assign unit_operands.value       = wk_value_ff;
   assign unit_operands.range       = wk_range_ff;
   assign unit_operands.position    = wk_pos_ff[4:0];
   assign unit_operands.probability = prob_ff;

   vp8bd_bit_unit u_bit_unit (
      .clock    (clock),
      .mul_en   (unit_mul_en),
      .operands (unit_operands),
      .result   (unit_result)
   );

   assign acc_index = 4'(bits_left_ff - 5'd1);

   always_comb begin
      state_in      = state_ff;
      partition_in  = partition_ff;
      cm_value_in   = cm_value_ff;
      cm_range_in   = cm_range_ff;
      cm_pos_in     = cm_pos_ff;
      cm_end_in     = cm_end_ff;
      cm_bytes_in   = cm_bytes_ff;
      cm_rd_in      = cm_rd_ff;
      cm_wr_in      = cm_wr_ff;
      cm_fill_in    = cm_fill_ff;
      rsp_valid_in  = rsp_valid_ff;
      wk_value_in   = wk_value_ff;
      wk_range_in   = wk_range_ff;
      wk_pos_in     = wk_pos_ff;
      wk_end_in     = wk_end_ff;
      wk_bytes_in   = wk_bytes_ff;
      wk_rd_in      = wk_rd_ff;
      wk_fill_in    = wk_fill_ff;
      bits_left_in  = bits_left_ff;
      prob_in       = prob_ff;
      acc_in        = acc_ff;
      refill_cnt_in = refill_cnt_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;
      mem_wr_en     = 1'b0;
      unit_mul_en   = 1'b0;

      // Configuration writes must arrive only while the decoder is idle; the block itself does not enforce this.
      if (csr_chan.valid) begin
         partition_in = LENGTH_BITS'(csr_chan.data);
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               res_value_in  = '0;
               res_status_in = vp8bd_pkg::ST_OK;
               state_in      = S_FINISH;
               case (req_chan.operation)
                  vp8bd_pkg::OP_RESTART: begin
                     cm_value_in = '0;
                     cm_range_in = vp8bd_pkg::RANGE_RESET;
                     cm_pos_in   = vp8bd_pkg::POSITION_RESET;
                     cm_end_in   = 1'b0;
                     cm_bytes_in = partition_ff;
                     cm_rd_in    = '0;
                     cm_wr_in    = '0;
                     cm_fill_in  = '0;
                  end
                  vp8bd_pkg::OP_PUSH: begin
                     if (cm_fill_ff == FILL_W'(BUFFER_DEPTH)) begin
                        res_status_in = vp8bd_pkg::ST_OVERFLOW;
                     end else begin
                        mem_wr_en  = 1'b1;
                        cm_wr_in   = ptr_next(cm_wr_ff);
                        cm_fill_in = cm_fill_ff + FILL_W'(1);
                     end
                  end
                  default: begin
                     wk_value_in = cm_value_ff;
                     wk_range_in = cm_range_ff;
                     wk_pos_in   = cm_pos_ff;
                     wk_end_in   = cm_end_ff;
                     wk_bytes_in = cm_bytes_ff;
                     wk_rd_in    = cm_rd_ff;
                     wk_fill_in  = cm_fill_ff;
                     acc_in      = '0;
                     if (req_chan.operation == vp8bd_pkg::OP_BOOL) begin
                        bits_left_in = CNT_W'(1);
                        prob_in      = req_chan.probability;
                        state_in     = S_BIT_START;
                     end else begin
                        prob_in = vp8bd_pkg::LITERAL_PROB;
                        if (req_chan.bit_count > vp8bd_pkg::LITERAL_MAX_BITS) begin
                           bits_left_in = vp8bd_pkg::LITERAL_MAX_BITS;
                        end else begin
                           bits_left_in = req_chan.bit_count;
                        end
                        // A zero-length literal completes at once with value zero.
                        if (req_chan.bit_count != '0) begin
                           state_in = S_BIT_START;
                        end
                     end
                  end
               endcase
            end
         end

         S_BIT_START: begin
            state_in = S_MUL;
            // A negative position calls for a refill before the bit.
            if (wk_pos_ff[POS_W-1]) begin
               if (wk_bytes_ff >= LENGTH_BITS'(4)) begin
                  if (wk_fill_ff < FILL_W'(3)) begin
                     res_value_in  = '0;
                     res_status_in = vp8bd_pkg::ST_RETRY;
                     state_in      = S_FINISH;
                  end else begin
                     refill_cnt_in = 2'd3;
                     state_in      = S_FETCH;
                  end
               end else if (wk_bytes_ff != '0) begin
                  if (wk_fill_ff == '0) begin
                     res_value_in  = '0;
                     res_status_in = vp8bd_pkg::ST_RETRY;
                     state_in      = S_FINISH;
                  end else begin
                     refill_cnt_in = 2'd1;
                     state_in      = S_FETCH;
                  end
               end else if (!wk_end_ff) begin
                  // The one zero byte of padding past the partition end.
                  wk_value_in = wk_value_ff << 8;
                  wk_pos_in   = wk_pos_ff + vp8bd_pkg::BYTE_STEP;
                  wk_end_in   = 1'b1;
               end else begin
                  wk_pos_in = '0;
               end
            end
         end

         S_FETCH: begin
            // The store reads the working read pointer during this cycle.
            state_in = S_LOAD;
         end

         S_LOAD: begin
            wk_value_in   = {wk_value_ff[CODE_W-9:0], mem_rd_data};
            wk_rd_in      = ptr_next(wk_rd_ff);
            wk_fill_in    = wk_fill_ff - FILL_W'(1);
            wk_bytes_in   = wk_bytes_ff - LENGTH_BITS'(1);
            wk_pos_in     = wk_pos_ff + vp8bd_pkg::BYTE_STEP;
            refill_cnt_in = refill_cnt_ff - 2'd1;
            if (refill_cnt_ff == 2'd1) begin
               state_in = S_MUL;
            end else begin
               state_in = S_FETCH;
            end
         end

         S_MUL: begin
            unit_mul_en = 1'b1;
            state_in    = S_DECIDE;
         end

         S_DECIDE: begin
            wk_value_in  = unit_result.value;
            wk_range_in  = unit_result.range;
            wk_pos_in    = wk_pos_ff - {3'b000, unit_result.shift};
            acc_in       = acc_ff | (VAL_W'(unit_result.decoded_bit) << acc_index);
            bits_left_in = bits_left_ff - CNT_W'(1);
            if (bits_left_ff == CNT_W'(1)) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_BIT_START;
            end
         end

         S_COMMIT: begin
            cm_value_in   = wk_value_ff;
            cm_range_in   = wk_range_ff;
            cm_pos_in     = wk_pos_ff;
            cm_end_in     = wk_end_ff;
            cm_bytes_in   = wk_bytes_ff;
            cm_rd_in      = wk_rd_ff;
            cm_fill_in    = wk_fill_ff;
            res_value_in  = acc_ff;
            res_status_in = vp8bd_pkg::ST_OK;
            state_in      = S_FINISH;
         end

         S_FINISH: begin
            // Wait here only while the previous response is still unclaimed.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_end_in    = cm_end_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         partition_ff <= '0;
         cm_value_ff  <= '0;
         cm_range_ff  <= vp8bd_pkg::RANGE_RESET;
         cm_pos_ff    <= vp8bd_pkg::POSITION_RESET;
         cm_end_ff    <= 1'b0;
         cm_bytes_ff  <= '0;
         cm_rd_ff     <= '0;
         cm_wr_ff     <= '0;
         cm_fill_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         partition_ff  <= partition_in;
         cm_value_ff   <= cm_value_in;
         cm_range_ff   <= cm_range_in;
         cm_pos_ff     <= cm_pos_in;
         cm_end_ff     <= cm_end_in;
         cm_bytes_ff   <= cm_bytes_in;
         cm_rd_ff      <= cm_rd_in;
         cm_wr_ff      <= cm_wr_in;
         cm_fill_ff    <= cm_fill_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_end_ff    <= rsp_end_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_value_ff   <= wk_value_in;
      wk_range_ff   <= wk_range_in;
      wk_pos_ff     <= wk_pos_in;
      wk_end_ff     <= wk_end_in;
      wk_bytes_ff   <= wk_bytes_in;
      wk_rd_ff      <= wk_rd_in;
      wk_fill_ff    <= wk_fill_in;
      bits_left_ff  <= bits_left_in;
      prob_ff       <= prob_in;
      acc_ff        <= acc_in;
      refill_cnt_ff <= refill_cnt_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.decoded_value = rsp_value_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.stream_ended  = rsp_end_ff;

endmodule

### rtl/vp8bd_byte_store.sv
// Partition byte buffer: one write port, one registered read port.
module vp8bd_byte_store #(
   parameter int DEPTH = vp8bd_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vp8bd_bit_unit.sv
// Shared bit decode unit: registered split multiply, then compare, subtract and normalize.
module vp8bd_bit_unit (
   input  logic                         clock,
   input  logic                         mul_en,
   input  vp8bd_pkg::bit_operands_type  operands,
   output vp8bd_pkg::bit_result_type    result
);

   logic [15:0] product;
   logic [7:0]  split_ff;

   assign product = operands.range * operands.probability;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         split_ff <= product[15:8];
      end
   end

   always_comb begin
      logic [vp8bd_pkg::CODE_BITS-1:0] shifted;
      logic [7:0]                      window;
      logic [8:0]                      split_plus;
      logic [8:0]                      range_wide;
      logic [7:0]                      range_low;
      logic [7:0]                      normalized;
      logic [2:0]                      shift;
      logic                            found;

      shifted    = operands.value >> operands.position;
      window     = shifted[7:0];
      split_plus = {1'b0, split_ff} + 9'd1;
      result.decoded_bit = (window > split_ff);
      if (result.decoded_bit) begin
         range_wide   = {1'b0, operands.range} - {1'b0, split_ff};
         result.value = operands.value
                      - (vp8bd_pkg::CODE_BITS'(split_plus) << operands.position);
      end else begin
         range_wide   = split_plus;
         result.value = operands.value;
      end
      // The interval never exceeds 255 here, so the low byte holds it.
      range_low = range_wide[7:0];
      shift = 3'd0;
      found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!found && range_low[i]) begin
            shift = 3'(7 - i);
            found = 1'b1;
         end
      end
      normalized   = range_low << shift;
      result.range = normalized - 8'd1;
      result.shift = shift;
   end

endmodule

### rtl/vp8bd_checker.sv
// Port-level checks of the VP8 boolean decoder and their binding.
module vp8bd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_decoded_value,
   input logic [1:0]  rsp_status,
   input logic        rsp_stream_ended
);

   // A stalled response keeps its payload.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decoded_value)
         && $stable(rsp_status) && $stable(rsp_stream_ended))
      else $error("response changed while stalled");

   // Reset leaves no response pending.
   rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending right after reset");

   // Taking a request makes the decoder busy; two requests are never taken back to back.
   busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in consecutive cycles");

   // A refused request reports a zero value.
   refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != vp8bd_pkg::ST_OK) |-> rsp_decoded_value == '0)
      else $error("refused request with nonzero value");

endmodule

bind vp8_bool_decoder vp8bd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_decoded_value (rsp_chan.decoded_value),
   .rsp_status        (rsp_chan.status),
   .rsp_stream_ended  (rsp_chan.stream_ended)
);

### dv/vp8_bool_decoder_checker.sv
// Response predictor and comparator for the VP8 boolean decoder.
module vp8_bool_decoder_checker (
   input  logic  clock,
   input  logic  reset,
   vp8bd_req_if  req_mon,
   vp8bd_rsp_if  rsp_mon,
   vp8bd_csr_if  csr_mon,
   output int    mismatch_count,
   output int    responses_seen,
   output int    responses_owed
);

   localparam int DEPTH    = vp8bd_pkg::BUFFER_DEPTH_DEFAULT;
   localparam int LEN_BITS = vp8bd_pkg::LENGTH_BITS_DEFAULT;

   typedef struct {
      bit [vp8bd_pkg::CODE_BITS-1:0] code;
      bit [7:0]                      span;
      int                            position;
      bit                            ended;
      bit [LEN_BITS-1:0]             remaining;
      int                            rd_ptr;
      int                            fill;
   } decoder_state_type;

   typedef struct {
      bit [vp8bd_pkg::VALUE_BITS-1:0] value;
      vp8bd_pkg::status_type          status;
      bit                             ended;
   } response_type;

   decoder_state_type dec;
   bit [7:0]          byte_mem [DEPTH];
   int                wr_ptr;
   bit [LEN_BITS-1:0] partition_length;
   response_type      expected_responses [$];

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: response %0d %s: got %0d, expected %0d",
               $time, responses_seen, what, got, want);
      mismatch_count++;
   endtask

   function automatic void clear_decoder(bit [LEN_BITS-1:0] len);
      dec.code      = '0;
      dec.span      = vp8bd_pkg::RANGE_RESET;
      dec.position  = int'($signed(vp8bd_pkg::POSITION_RESET));
      dec.ended     = 1'b0;
      dec.remaining = len;
      dec.rd_ptr    = 0;
      dec.fill      = 0;
      wr_ptr        = 0;
   endfunction

   function automatic bit [7:0] pop_stored(inout decoder_state_type s);
      bit [7:0] b;
      b           = byte_mem[s.rd_ptr];
      s.rd_ptr    = (s.rd_ptr + 1) % DEPTH;
      s.fill      = s.fill - 1;
      s.remaining = s.remaining - 1'b1;
      return b;
   endfunction

   // Works out the response to one request and advances the decoder copy.
   // A decode that runs short of buffered bytes at any refill leaves the
   // state untouched and answers with a retry.
   function automatic response_type predict_response(vp8bd_pkg::op_type op, bit [7:0] data,
                                                     bit [7:0] prob_in, bit [4:0] count_in);
      response_type      rsp;
      decoder_state_type work;
      bit [7:0]          prob, b0, b1, b2;
      bit [31:0]         span_w, split, window;
      int                bits_left, pos, shift;
      bit                short_buf, decoded;

      rsp.value  = '0;
      rsp.status = vp8bd_pkg::ST_OK;
      short_buf  = 1'b0;
      bits_left  = 0;
      prob       = vp8bd_pkg::LITERAL_PROB;
      case (op)
         vp8bd_pkg::OP_RESTART: clear_decoder(partition_length);
         vp8bd_pkg::OP_PUSH: begin
            if (dec.fill >= DEPTH) begin
               rsp.status = vp8bd_pkg::ST_OVERFLOW;
            end else begin
               byte_mem[wr_ptr] = data;
               wr_ptr           = (wr_ptr + 1) % DEPTH;
               dec.fill++;
            end
         end
         vp8bd_pkg::OP_BOOL: begin
            bits_left = 1;
            prob      = prob_in;
         end
         default: bits_left = int'((count_in > vp8bd_pkg::LITERAL_MAX_BITS)
                                   ? vp8bd_pkg::LITERAL_MAX_BITS : count_in);
      endcase

      if (op == vp8bd_pkg::OP_BOOL || op == vp8bd_pkg::OP_LITERAL) begin
         work = dec;
         while (bits_left > 0 && !short_buf) begin
            if (work.position < 0) begin
               if (work.remaining >= 4) begin
                  if (work.fill < 3) begin
                     short_buf = 1'b1;
                  end else begin
                     b0 = pop_stored(work);
                     b1 = pop_stored(work);
                     b2 = pop_stored(work);
                     work.code     = {work.code[7:0], b0, b1, b2};
                     work.position += 24;
                  end
               end else if (work.remaining != 0) begin
                  if (work.fill < 1) begin
                     short_buf = 1'b1;
                  end else begin
                     b0 = pop_stored(work);
                     work.code     = {work.code[23:0], b0};
                     work.position += 8;
                  end
               end else if (!work.ended) begin
                  work.code     = {work.code[23:0], 8'h00};
                  work.position += 8;
                  work.ended    = 1'b1;
               end else begin
                  work.position = 0;
               end
            end
            if (!short_buf) begin
               pos     = work.position & 31;
               split   = (32'(work.span) * 32'(prob)) >> 8;
               window  = (work.code >> pos) & 32'hFF;
               decoded = window > split;
               if (decoded) begin
                  span_w    = 32'(work.span) - split;
                  work.code = work.code - ((split + 32'd1) << pos);
               end else begin
                  span_w = split + 32'd1;
               end
               shift = 0;
               while (span_w < 32'd128) begin
                  span_w = span_w << 1;
                  shift++;
               end
               work.position -= shift;
               work.span      = 8'(span_w - 32'd1);
               bits_left--;
               rsp.value[bits_left] = decoded;
            end
         end
         if (short_buf) begin
            rsp.value  = '0;
            rsp.status = vp8bd_pkg::ST_RETRY;
         end else begin
            dec = work;
         end
      end
      rsp.ended = dec.ended;
      return rsp;
   endfunction

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         clear_decoder('0);
         partition_length = '0;
         mismatch_count   = 0;
         expected_responses.delete();
         responses_seen <= 0;
         responses_owed <= 0;
      end else begin
         // Responses are matched first so that one never pairs with a request
         // taken at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("arrived with nothing outstanding",
                               int'(rsp_mon.decoded_value), 0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_mon.decoded_value !== want.value)
                  report_mismatch("decoded_value", int'(rsp_mon.decoded_value),
                                  int'(want.value));
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", int'(rsp_mon.status), int'(want.status));
               if (rsp_mon.stream_ended !== want.ended)
                  report_mismatch("stream_ended", int'(rsp_mon.stream_ended),
                                  int'(want.ended));
            end
            responses_seen <= responses_seen + 1;
         end
         if (csr_mon.valid && csr_mon.ready)
            partition_length = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            expected_responses.push_back(
               predict_response(vp8bd_pkg::op_type'(req_mon.operation),
                                req_mon.data_byte,
                                req_mon.probability,
                                req_mon.bit_count));
         responses_owed <= expected_responses.size();
      end
   end

endmodule

### dv/vp8_bool_decoder_test.sv
// Testbench top for the VP8 boolean decoder: stimulus, response back-pressure and verdict.
module vp8_bool_decoder_test;

   // Number of requests after which the random part stops opening new phases.
   localparam int ITEM_TARGET = 1850;
   // Length of the deliberate response hold-off, in cycles.
   localparam int LONG_HOLD   = 400;
   // Cycles without any transfer on any channel before the run is declared hung.
   // The slowest legal gap is the long hold plus one literal and a sender gap,
   // so this leaves ample margin.
   localparam int STALL_LIMIT = 4000;
   // Quiet cycles after the last response before the verdict is given.
   localparam int TAIL_CYCLES = 64;
   localparam int DEPTH       = vp8bd_pkg::BUFFER_DEPTH_DEFAULT;
   localparam int LEN_BITS    = vp8bd_pkg::LENGTH_BITS_DEFAULT;
   localparam bit [LEN_BITS-1:0] MAX_LENGTH = '1;

   // Receiver behaviors that the response side cycles through.
   typedef enum int {
      READY_FLOW,
      READY_COIN,
      READY_SPARSE,
      READY_STRETCH
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset;

   int items_sent;
   int burst_left;
   int long_holds_asked;
   int mismatch_count;
   int responses_seen;
   int responses_owed;

   vp8bd_req_if req_chan();
   vp8bd_rsp_if rsp_chan();
   vp8bd_csr_if csr_chan();

   vp8_bool_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   vp8_bool_decoder_checker response_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatch_count),
      .responses_seen (responses_seen),
      .responses_owed (responses_owed)
   );

   always #5 clock = ~clock;

   // Offers one request and holds it until the decoder takes it. The sender
   // runs in bursts; when a burst is used up it may drop valid for a random
   // gap, so idle cycles land on every phase of the decoder's sequencing.
   // Valid is never lowered and raised within one step.
   task automatic send_request(vp8bd_pkg::op_type op, bit [7:0] data, bit [7:0] prob,
                               bit [4:0] count);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= op;
      req_chan.data_byte   <= data;
      req_chan.probability <= prob;
      req_chan.bit_count   <= count;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         // At random one burst in four is a long run; a gap comes only after a burst.
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops offering requests until every transfer taken so far has been
   // answered. Each request yields exactly one response, so a short settle
   // period is all that is needed before the decoder counts as idle.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      while (responses_seen != items_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_partition_length(bit [LEN_BITS-1:0] len);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= len;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Stimulus and verdict.
   initial begin
      int                 phase;
      int                 pushed;
      int                 preload;
      int                 roll;
      bit [LEN_BITS-1:0]  len;
      bit [7:0]           pattern;
      bit [7:0]           prob;
      bit [4:0]           count;

      req_chan.valid       = 1'b0;
      req_chan.operation   = vp8bd_pkg::OP_RESTART;
      req_chan.data_byte   = '0;
      req_chan.probability = '0;
      req_chan.bit_count   = '0;
      csr_chan.valid       = 1'b0;
      csr_chan.data        = '0;
      reset                = 1'b1;
      items_sent           = 0;
      burst_left           = 1;
      long_holds_asked     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Out of reset the partition length is zero, so the first
      // bool decode shifts in the single zero pad byte and ends the stream; the
      // literal after it runs with the bit position pinned at zero, and its bit
      // count of 31 saturates to 16. A zero-bit literal returns zero untouched.
      send_request(vp8bd_pkg::OP_BOOL, 8'($urandom), 8'd0, 5'($urandom));
      send_request(vp8bd_pkg::OP_LITERAL, 8'($urandom), 8'($urandom), 5'd31);
      send_request(vp8bd_pkg::OP_LITERAL, 8'($urandom), 8'($urandom), 5'd0);
      drain_responses();

      // With the longest partition every refill wants three bytes. A decode
      // right after restart finds the buffer empty and must be refused with a
      // retry. Filling the buffer to the brim and pushing once more must give
      // an overflow, after which bool decodes at probabilities 255 and 1 and a 16-bit literal run.
      write_partition_length(MAX_LENGTH);
      send_request(vp8bd_pkg::OP_RESTART, 8'($urandom), 8'($urandom), 5'($urandom));
      send_request(vp8bd_pkg::OP_BOOL, 8'($urandom), 8'd255, 5'($urandom));
      for (int i = 0; i <= DEPTH; i++) begin
         case (i % 4)
            0:       pattern = 8'h00;
            1:       pattern = 8'hFF;
            2:       pattern = 8'h80;
            default: pattern = 8'($urandom);
         endcase
         send_request(vp8bd_pkg::OP_PUSH, pattern, 8'($urandom), 5'($urandom));
      end
      send_request(vp8bd_pkg::OP_BOOL, 8'($urandom), 8'd255, 5'($urandom));
      send_request(vp8bd_pkg::OP_LITERAL, 8'($urandom), 8'($urandom), 5'd16);
      send_request(vp8bd_pkg::OP_BOOL, 8'($urandom), 8'd1, 5'($urandom));

      // Random part, in phases. Each phase waits for the decoder to go idle,
      // picks a partition length, restarts and preloads a few bytes, then runs
      // a mix that mostly feeds the partition and decodes it. Short partitions
      // run into the end of the stream; pushes past the partition length,
      // stray restarts, overflows and retries make up the noise.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_responses();
         case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = LEN_BITS'($urandom_range(1, 3));
            2:       len = LEN_BITS'(4);
            3, 4, 5: len = LEN_BITS'($urandom_range(5, 40));
            6:       len = LEN_BITS'($urandom_range(41, 200));
            7:       len = MAX_LENGTH;
            8:       len = LEN_BITS'($urandom);
            default: len = LEN_BITS'($urandom_range(1, 12));
         endcase
         write_partition_length(len);
         send_request(vp8bd_pkg::OP_RESTART, 8'($urandom), 8'($urandom), 5'($urandom));
         pushed  = 0;
         preload = $urandom_range(3, 12);
         while (pushed < preload && pushed < len) begin
            send_request(vp8bd_pkg::OP_PUSH, 8'($urandom), 8'($urandom), 5'($urandom));
            pushed++;
         end

         // Twice in the run the receiver holds off for a long stretch while
         // this side keeps offering, so the decoder fills up and stalls its
         // request channel.
         if (phase == 3 || phase == 17)
            long_holds_asked <= long_holds_asked + 1;

         repeat ($urandom_range(30, 90)) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               send_request(vp8bd_pkg::OP_RESTART, 8'($urandom), 8'($urandom),
                            5'($urandom));
               pushed = 0;
            end else if (roll < ((pushed < len) ? 32 : 6)) begin
               send_request(vp8bd_pkg::OP_PUSH, 8'($urandom), 8'($urandom), 5'($urandom));
               pushed++;
            end else if (roll < 75) begin
               case ($urandom_range(0, 7))
                  0:       prob = 8'd0;
                  1:       prob = 8'd255;
                  default: prob = 8'($urandom);
               endcase
               send_request(vp8bd_pkg::OP_BOOL, 8'($urandom), prob, 5'($urandom));
            end else begin
               case ($urandom_range(0, 9))
                  0:       count = 5'd0;
                  1:       count = 5'd16;
                  2:       count = 5'($urandom_range(17, 31));
                  default: count = 5'($urandom_range(1, 8));
               endcase
               send_request(vp8bd_pkg::OP_LITERAL, 8'($urandom), 8'($urandom), count);
            end
         end
         phase++;
      end

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && responses_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Response side. It wanders between always ready, coin-flip stalls, rare
   // acceptance and stretches of stall, and serves long hold-offs on request.
   // The hold-off is counted here, in this process, not in the sender's.
   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             stretch_left;
      int             long_holds_done;

      rsp_chan.ready  = 1'b0;
      mode            = READY_FLOW;
      mode_left       = 0;
      stretch_left    = 0;
      long_holds_done = 0;
      forever begin
         @(posedge clock);
         if (long_holds_done != long_holds_asked) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_holds_done++;
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
               READY_FLOW:   rsp_chan.ready <= 1'b1;
               READY_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: begin
                  if (stretch_left > 0) begin
                     rsp_chan.ready <= 1'b0;
                     stretch_left--;
                  end else begin
                     rsp_chan.ready <= 1'b1;
                     if ($urandom_range(0, 7) == 0)
                        stretch_left = $urandom_range(5, 30);
                  end
               end
            endcase
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

endmodule

### sim.f
rtl/vp8bd_pkg.sv
rtl/vp8bd_req_if.sv
rtl/vp8bd_rsp_if.sv
rtl/vp8bd_csr_if.sv
rtl/vp8bd_byte_store.sv
rtl/vp8bd_bit_unit.sv
rtl/vp8_bool_decoder.sv
rtl/vp8bd_checker.sv
dv/vp8_bool_decoder_checker.sv
dv/vp8_bool_decoder_test.sv
